>>> rtl/ptpg_pkg.sv
// ----------------------------------------------------------------------------
// ptpg_pkg
// Shared types, constants and table builders for the test pattern generator.
// ----------------------------------------------------------------------------
package ptpg_pkg;

    // Table geometry
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int SINE_W     = 8;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int COLOR_W    = 16;
    localparam int COORD_W    = 10;
    localparam int HEIGHT_W   = 11;
    localparam int BAND_W     = 3;
    localparam int NUM_BANDS  = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
    localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET = HEIGHT_W'(480);

    typedef enum logic [1:0] {
        MODE_SOLID  = 2'd0,
        MODE_PLASMA = 2'd1,
        MODE_BARS   = 2'd2
    } mode_t;

    // Fixed-point constants for the sine build
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] DIV_255_3 = 64'd255 * 64'd255 * 64'd255;
    localparam logic [63:0] DIV_255_5 = 64'd255 * 64'd255 * 64'd255 * 64'd255 * 64'd255;

    // Bar colors, already byte-swapped: red, green, blue, white, black
    typedef logic [NUM_BANDS-1:0][COLOR_W-1:0] bar_tab_t;
    localparam bar_tab_t BAR_COLORS = '{
        16'h0000, 16'hFFFF, 16'h1F00, 16'hE007, 16'h00F8
    };

    // Quarter-wave table: upper byte is the falling half value, lower byte
    // the rising half value, indexed by angle 0..255 of a quarter turn.
    typedef logic [PAL_DEPTH-1:0][2*SINE_W-1:0] quad_tab_t;
    typedef logic [PAL_DEPTH-1:0][COLOR_W-1:0]  pal_tab_t;

    // Write port of the table load sweep
    typedef struct packed {
        logic                 sine_wr_en;
        logic                 pal_wr_en;
        logic [SINE_AW-1:0]   addr;
        logic [SINE_W-1:0]    sine_data;
        logic [COLOR_W-1:0]   pal_data;
    } fill_wr_t;

    // sin(pi*a/512) in Q30 by a Taylor series to x^17
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] prod;
        x    = (a * PI_Q30) >> 9;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int k = 1; k <= 8; k++) begin
            prod = (term * x2) >> 30;
            case (k)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if ((k % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        if (a == 64'd0 || neg >= pos) begin
            return 64'd0;
        end
        pos = pos - neg;
        return (pos > Q30_ONE) ? Q30_ONE : pos;
    endfunction

    function automatic quad_tab_t build_quad_table();
        quad_tab_t   tab;
        logic [63:0] s;
        logic [63:0] hi;
        logic [63:0] lo;
        for (int a = 0; a < PAL_DEPTH; a++) begin
            s      = quarter_sine_q30(64'(a));
            hi     = (64'd255 * (Q30_ONE + s)) >> 31;
            lo     = (64'd255 * (Q30_ONE - s)) >> 31;
            tab[a] = {lo[SINE_W-1:0], hi[SINE_W-1:0]};
        end
        return tab;
    endfunction

    // Palette: r = i^6/255^5, g = i^4/255^3, b = i^2/255, RGB565 byte-swapped
    function automatic pal_tab_t build_pal_table();
        pal_tab_t    tab;
        logic [63:0] i2;
        logic [63:0] i4;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [15:0] c;
        for (int i = 0; i < PAL_DEPTH; i++) begin
            i2     = 64'(i) * 64'(i);
            i4     = i2 * i2;
            b      = i2 / 64'd255;
            g      = i4 / DIV_255_3;
            r      = (i4 * i2) / DIV_255_5;
            c      = {r[7:3], g[7:2], b[7:3]};
            tab[i] = {c[7:0], c[15:8]};
        end
        return tab;
    endfunction

    localparam quad_tab_t QUAD_TABLE    = build_quad_table();
    localparam pal_tab_t  PALETTE_TABLE = build_pal_table();

endpackage

>>> rtl/ptpg_ram.sv
// ----------------------------------------------------------------------------
// ptpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ptpg_init.sv
// ----------------------------------------------------------------------------
// ptpg_init
// Table load sequencer: after reset, sweeps the sine and palette memories
// once, one entry per cycle, from the constant build tables.
// ----------------------------------------------------------------------------
module ptpg_init (
    input  logic               aclk,
    input  logic               aresetn,
    output ptpg_pkg::fill_wr_t fill_wr,
    output logic               fill_done
);
    import ptpg_pkg::*;

    logic [SINE_AW-1:0] cnt_reg;
    logic [SINE_AW-1:0] cnt_next;
    logic               done_reg;
    logic               done_next;

    logic [1:0]         quadrant;
    logic [PAL_AW-1:0]  step;
    logic [PAL_AW-1:0]  quad_idx;
    logic               peak;
    logic [2*SINE_W-1:0] quad_entry;
    logic [SINE_W-1:0]  sine_val;

    // Sweep counter
    always_comb begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (!done_reg) begin
            cnt_next = cnt_reg + SINE_AW'(1);
            if (cnt_reg == SINE_AW'(SINE_DEPTH - 1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Full sine from the quarter wave: odd quadrants mirror, even halves rise
    assign quadrant   = cnt_reg[SINE_AW-1 -: 2];
    assign step       = cnt_reg[PAL_AW-1:0];
    assign quad_idx   = quadrant[0] ? (PAL_AW'(0) - step) : step;
    assign peak       = quadrant[0] && (step == '0);
    assign quad_entry = QUAD_TABLE[quad_idx];

    always_comb begin
        if (!quadrant[1]) begin
            sine_val = peak ? SINE_W'(255) : quad_entry[SINE_W-1:0];
        end else begin
            sine_val = peak ? SINE_W'(0) : quad_entry[2*SINE_W-1:SINE_W];
        end
    end

    assign fill_wr.sine_wr_en = !done_reg;
    assign fill_wr.pal_wr_en  = !done_reg && (cnt_reg[SINE_AW-1:PAL_AW] == '0);
    assign fill_wr.addr       = cnt_reg;
    assign fill_wr.sine_data  = sine_val;
    assign fill_wr.pal_data   = PALETTE_TABLE[cnt_reg[PAL_AW-1:0]];
    assign fill_done          = done_reg;

endmodule

>>> rtl/plasma_test_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// plasma_test_pattern_generator_unit
// Video test pattern source: solid palette color, plasma or five color bars.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// byte-swapped RGB565 color per pixel, in order; each color passes the sine
// memory read, the palette memory read and the output register. The rate is
// set by the sine lookups: each of the three plasma terms reads its own copy
// of the 1024-entry sine memory, and the sum then reads the 256-entry palette
// memory in the following stage. After reset the block loads these memories
// with s_tready low; configuration writes are taken during that time. Write
// pattern_mode and frame_height only while no pixel is in flight.
module plasma_test_pattern_generator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // pixel_x, pixel_y, frame_time, pad
    // Color output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // pixel_color
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptpg_pkg::HEIGHT_W-1:0]     cfg_data
);
    import ptpg_pkg::*;

    // Configuration registers and height multiples for the bar bands
    mode_t                mode_reg;
    logic [HEIGHT_W-1:0]  h1_reg;
    logic [HEIGHT_W:0]    h2_reg;
    logic [HEIGHT_W+1:0]  h3_reg;
    logic [HEIGHT_W+1:0]  h4_reg;

    fill_wr_t             fill_wr;
    logic                 fill_done;

    // Pipeline control
    logic                 en1;
    logic                 en2;
    logic                 en3;
    logic                 accept;

    // Stage 0 decode
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [COORD_W-1:0]   pt;
    logic [SINE_AW-1:0]   addr_a;
    logic [SINE_AW-1:0]   addr_b;
    logic [SINE_AW-1:0]   addr_c;
    logic [COORD_W:0]     xyt_sum;
    logic [HEIGHT_W+1:0]  y5;
    logic                 beyond;
    logic                 ge1;
    logic                 ge2;
    logic                 ge3;
    logic                 ge4;
    logic [BAND_W-1:0]    band0;

    // Stage 1: sine data out of memory
    logic                 s1_valid_reg;
    mode_t                s1_mode_reg;
    logic [PAL_AW-1:0]    s1_tidx_reg;
    logic [BAND_W-1:0]    s1_band_reg;
    logic [SINE_W-1:0]    sine_a;
    logic [SINE_W-1:0]    sine_b;
    logic [SINE_W-1:0]    sine_c;
    logic [SINE_W+1:0]    sine_sum;
    logic [PAL_AW-1:0]    pal_addr;

    // Stage 2: palette data out of memory
    logic                 s2_valid_reg;
    mode_t                s2_mode_reg;
    logic [BAND_W-1:0]    s2_band_reg;
    logic [COLOR_W-1:0]   pal_data;
    logic [COLOR_W-1:0]   color;

    // Output register
    logic                 m_valid_reg;
    logic [COLOR_W-1:0]   m_data_reg;

    // Configuration register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLASMA;
            h1_reg   <= HEIGHT_RESET;
            h2_reg   <= (HEIGHT_W+1)'(2 * HEIGHT_RESET);
            h3_reg   <= (HEIGHT_W+2)'(3 * HEIGHT_RESET);
            h4_reg   <= (HEIGHT_W+2)'(4 * HEIGHT_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE: begin
                    mode_reg <= mode_t'(cfg_data[1:0]);
                end
                REG_HEIGHT: begin
                    h1_reg <= cfg_data;
                    h2_reg <= {cfg_data, 1'b0};
                    h3_reg <= {1'b0, cfg_data, 1'b0} + {2'b00, cfg_data};
                    h4_reg <= {cfg_data, 2'b00};
                end
                default: begin
                end
            endcase
        end
    end

    // Table load sweep
    ptpg_init u_init (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fill_wr   (fill_wr),
        .fill_done (fill_done)
    );

    // Stall chain: each stage moves when empty or when the next one moves
    assign en3      = !m_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = fill_done && en1;
    assign accept   = s_tvalid && s_tready;

    // Stage 0: sine addresses and bar band
    assign px = s_tdata[COORD_W-1:0];
    assign py = s_tdata[2*COORD_W-1:COORD_W];
    assign pt = s_tdata[3*COORD_W-1:2*COORD_W];

    assign addr_a  = {px[COORD_W-3:0], 2'b00} + pt;
    assign addr_b  = {py[COORD_W-2:0], 1'b0} + py + pt;
    assign xyt_sum = {1'b0, px} + {1'b0, py} + {1'b0, pt};
    assign addr_c  = {xyt_sum[COORD_W-2:0], 1'b0};

    assign y5     = {3'b000, py} + {1'b0, py, 2'b00};
    assign beyond = (h1_reg == '0) || ({1'b0, py} >= h1_reg);
    assign ge1    = y5 >= {2'b00, h1_reg};
    assign ge2    = y5 >= {1'b0, h2_reg};
    assign ge3    = y5 >= h3_reg;
    assign ge4    = y5 >= h4_reg;
    assign band0  = beyond ? BAND_W'(NUM_BANDS - 1)
                           : ({2'b00, ge1} + {2'b00, ge2} + {2'b00, ge3} + {2'b00, ge4});

    // Three copies of the sine memory, one per plasma term
    ptpg_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sine_a (
        .aclk    (aclk),
        .wr_en   (fill_wr.sine_wr_en),
        .wr_addr (fill_wr.addr),
        .wr_data (fill_wr.sine_data),
        .rd_en   (en1),
        .rd_addr (addr_a),
        .rd_data (sine_a)
    );

    ptpg_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sine_b (
        .aclk    (aclk),
        .wr_en   (fill_wr.sine_wr_en),
        .wr_addr (fill_wr.addr),
        .wr_data (fill_wr.sine_data),
        .rd_en   (en1),
        .rd_addr (addr_b),
        .rd_data (sine_b)
    );

    ptpg_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sine_c (
        .aclk    (aclk),
        .wr_en   (fill_wr.sine_wr_en),
        .wr_addr (fill_wr.addr),
        .wr_data (fill_wr.sine_data),
        .rd_en   (en1),
        .rd_addr (addr_c),
        .rd_data (sine_c)
    );

    // Stage 1 sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_mode_reg <= mode_reg;
            s1_tidx_reg <= {pt[PAL_AW-3:0], 2'b00};
            s1_band_reg <= band0;
        end
    end

    // Stage 1: plasma sum picks the palette entry, solid uses the time
    assign sine_sum = {2'b00, sine_a} + {2'b00, sine_b} + {2'b00, sine_c};
    assign pal_addr = (s1_mode_reg == MODE_SOLID) ? s1_tidx_reg : sine_sum[PAL_AW-1:0];

    ptpg_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_palette (
        .aclk    (aclk),
        .wr_en   (fill_wr.pal_wr_en),
        .wr_addr (fill_wr.addr[PAL_AW-1:0]),
        .wr_data (fill_wr.pal_data),
        .rd_en   (en2),
        .rd_addr (pal_addr),
        .rd_data (pal_data)
    );

    // Stage 2 sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_mode_reg <= s1_mode_reg;
            s2_band_reg <= s1_band_reg;
        end
    end

    // Stage 2: final color select; unused mode gives black
    always_comb begin
        case (s2_mode_reg)
            MODE_SOLID, MODE_PLASMA: color = pal_data;
            MODE_BARS:               color = BAR_COLORS[s2_band_reg];
            default:                 color = '0;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en3) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            m_data_reg <= color;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the plasma test pattern generator.
// Pixels stream in through a queue-fed driver; every returned color is
// compared with a local model of the sine and palette tables, the plasma
// sum and the color bar bands. Runs directed corners, then random batches
// under several register settings and idle profiles, including a long
// output stall.
// ----------------------------------------------------------------------------
module tb;

    import ptpg_pkg::*;

    localparam int          CLK_HALF         = 5;
    localparam int          RESET_CYCLES     = 8;
    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          SINK_HOLD_CYCLES = 300;
    localparam int          BATCHES          = 12;
    localparam int          BATCH_ITEMS      = 120;
    localparam int          TAIL_CYCLES      = 16;
    localparam logic [1:0]  MODE_UNUSED      = 2'd3;
    localparam logic [63:0] FX_ONE           = 64'd1073741824;
    localparam logic [63:0] FX_PI            = 64'd3373259426;

    // Bar colors in wire byte order: red, green, blue, white, black
    localparam logic [15:0] BAND_COLOR [5] = '{16'h00F8, 16'hE007, 16'h1F00,
                                               16'hFFFF, 16'h0000};

    // One pixel request, x in the low bits as on s_tdata
    typedef struct packed {
        logic [9:0] t;
        logic [9:0] y;
        logic [9:0] x;
    } pixel_t;

    // DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [HEIGHT_W-1:0]  cfg_data  = '0;

    // Local copy of the block's tables and registers
    logic [7:0]          sine_lut  [1024];
    logic [15:0]         color_lut [256];
    logic [1:0]          mode_q    = MODE_PLASMA;
    logic [HEIGHT_W-1:0] height_q  = HEIGHT_RESET;

    // Traffic state
    pixel_t      pixels_pending [$];
    logic [15:0] colors_due     [$];
    pixel_t      offered;
    logic [15:0] want_color;
    int          src_idle_pct   = 0;
    int          dst_idle_pct   = 0;
    logic        stall_sink_go  = 1'b0;
    logic        sink_hold      = 1'b0;
    int          errors         = 0;

    plasma_test_pattern_generator_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // pixel_x, pixel_y, frame_time, pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // pixel_color
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // sin(pi*a/512) in Q30, Taylor series to x^17, clamped to [0, 1]
    function automatic logic [63:0] sin_quarter_q30(input int unsigned a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        if (a == 0) return 64'd0;
        if (a >= 256) return FX_ONE;
        x    = (64'(a) * FX_PI) / 64'd512;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) neg += term;
            else pos += term;
        end
        if (neg >= pos) return 64'd0;
        pos -= neg;
        return (pos > FX_ONE) ? FX_ONE : pos;
    endfunction

    // Fill the sine and palette tables
    task automatic build_luts();
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] i2;
        logic [63:0] i4;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [15:0] c;
        int unsigned quad;
        int unsigned ang;
        for (int i = 0; i < 1024; i++) begin
            quad = (i >> 8) & 3;
            ang  = i & 255;
            s    = sin_quarter_q30((quad % 2 == 1) ? 256 - ang : ang);
            if (quad < 2) v = (64'd255 * (FX_ONE + s)) >> 31;
            else v = (64'd255 * (FX_ONE - s)) >> 31;
            sine_lut[i] = (v > 64'd255) ? 8'hFF : v[7:0];
        end
        for (int i = 0; i < 256; i++) begin
            i2 = 64'(i) * 64'(i);
            i4 = i2 * i2;
            b  = i2 / 64'd255;
            g  = i4 / (64'd255 * 64'd255 * 64'd255);
            r  = (i4 * i2) / (64'd255 * 64'd255 * 64'd255 * 64'd255 * 64'd255);
            c  = {r[7:3], g[7:2], b[7:3]};
            color_lut[i] = {c[7:0], c[15:8]};
        end
    endtask

    // Expected color of one pixel under the current register settings
    function automatic logic [15:0] expected_color(input pixel_t p);
        logic [9:0] ia;
        logic [9:0] ib;
        logic [9:0] ic;
        logic [7:0] idx;
        int         band;
        case (mode_q)
            MODE_SOLID: begin
                return color_lut[{p.t[5:0], 2'b00}];
            end
            MODE_PLASMA: begin
                ia  = {p.x[7:0], 2'b00} + p.t;
                ib  = p.y * 10'd3 + p.t;
                ic  = (p.x + p.y + p.t) << 1;
                idx = sine_lut[ia] + sine_lut[ib] + sine_lut[ic];
                return color_lut[idx];
            end
            MODE_BARS: begin
                band = 4;
                if (height_q != 0 && p.y < height_q) begin
                    band = (int'(p.y) * 5) / int'(height_q);
                    if (band > 4) band = 4;
                end
                return BAND_COLOR[band];
            end
            default: return 16'h0000;
        endcase
    endfunction

    // Register write; the local copy follows at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= HEIGHT_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MODE) mode_q = 2'(val);
        else if (idx == REG_HEIGHT) height_q = HEIGHT_W'(val);
    endtask

    task automatic push_pixel(input int unsigned x, input int unsigned y, input int unsigned t);
        pixel_t p;
        p.x = 10'(x);
        p.y = 10'(y);
        p.t = 10'(t);
        pixels_pending.push_back(p);
    endtask

    // Hold off until every queued pixel has gone through and come back
    task automatic drain();
        while (pixels_pending.size() != 0 || s_tvalid || colors_due.size() != 0)
            @(posedge aclk);
    endtask

    // Random pixels; in bar mode about half of them are drawn inside the frame
    task automatic push_random(input int n);
        int unsigned y;
        int unsigned lines;
        for (int i = 0; i < n; i++) begin
            y     = $urandom_range(1023);
            lines = (height_q > 1024) ? 1024 : height_q;
            if (mode_q == MODE_BARS && lines > 1 && $urandom_range(1) == 1)
                y = $urandom_range(lines - 1);
            push_pixel($urandom_range(1023), y, $urandom_range(1023));
        end
    endtask

    // Random register setting with the extremes favored
    task automatic pick_config();
        int unsigned roll;
        int unsigned h;
        roll = $urandom_range(9);
        if (roll < 2) write_reg(REG_MODE, MODE_SOLID);
        else if (roll < 6) write_reg(REG_MODE, MODE_PLASMA);
        else if (roll < 9) write_reg(REG_MODE, MODE_BARS);
        else write_reg(REG_MODE, MODE_UNUSED);
        case ($urandom_range(8))
            0:       h = 0;
            1:       h = 1;
            2:       h = 2;
            3:       h = 5;
            4:       h = 480;
            5:       h = 1023;
            6:       h = 1024;
            7:       h = 2047;
            default: h = $urandom_range(2047);
        endcase
        write_reg(REG_HEIGHT, h);
    endtask

    // Input driver: offers the next pending pixel once the last one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) colors_due.push_back(expected_color(offered));
            if (!s_tvalid || s_tready) begin
                if (pixels_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered = pixels_pending.pop_front();
                    s_tdata  <= {2'b00, offered};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each color transaction with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (colors_due.size() == 0) begin
                    $display("%0t: unexpected pixel_color, expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want_color = colors_due.pop_front();
                    if (m_tdata !== want_color) begin
                        $display("%0t: pixel_color mismatch, expected %h, got %h",
                                 $time, want_color, m_tdata);
                        errors++;
                    end
                end
            end
            m_tready <= !sink_hold && ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Long output stall so the pipeline fills and pushes back on the input
    initial begin
        wait (stall_sink_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Stimulus
    initial begin
        build_luts();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Plasma with reset settings: coordinate and time extremes
        src_idle_pct = 21;
        dst_idle_pct = 58;
        push_pixel(0, 0, 0);
        push_pixel(1023, 1023, 1023);
        push_pixel(1023, 0, 512);
        push_pixel(0, 1023, 256);
        push_pixel(512, 512, 768);
        drain();

        // Solid color follows the time only
        write_reg(REG_MODE, MODE_SOLID);
        push_pixel(5, 7, 0);
        push_pixel(1023, 1023, 1023);
        push_pixel(0, 0, 63);
        push_pixel(0, 0, 64);
        drain();

        // Bars at the default height, band edges and lines past the frame
        write_reg(REG_MODE, MODE_BARS);
        push_pixel(0, 0, 0);
        push_pixel(1023, 95, 1023);
        push_pixel(0, 96, 0);
        push_pixel(0, 479, 0);
        push_pixel(0, 480, 0);
        push_pixel(0, 1023, 0);
        drain();

        // Zero height: everything black
        write_reg(REG_HEIGHT, 0);
        push_pixel(0, 0, 0);
        drain();

        // One-line frame
        write_reg(REG_HEIGHT, 1);
        push_pixel(0, 0, 0);
        push_pixel(0, 1, 0);
        drain();

        // Full 1024-line frame, last band boundary
        write_reg(REG_HEIGHT, 1024);
        push_pixel(0, 1023, 0);
        push_pixel(0, 819, 0);
        push_pixel(0, 820, 0);
        drain();

        // Height beyond any line
        write_reg(REG_HEIGHT, 2047);
        push_pixel(0, 1023, 0);
        drain();

        // Unused mode reads black
        write_reg(REG_MODE, MODE_UNUSED);
        push_pixel(1023, 1023, 1023);
        push_pixel(0, 0, 0);
        drain();

        // Random batches, each under its own register setting
        for (int k = 0; k < BATCHES; k++) begin
            if (k < BATCHES / 3) begin
                src_idle_pct = 21;
                dst_idle_pct = 58;
            end else if (k < 2 * BATCHES / 3) begin
                src_idle_pct = 58;
                dst_idle_pct = 21;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            pick_config();
            if (k == 0) stall_sink_go = 1'b1;
            push_random(BATCH_ITEMS);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

endmodule
